// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; expects signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define CMPS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cmps_checker: property violated");

// clocked property that is also checked during reset
`define CMPS_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("cmps_checker: property violated during or after reset");

`endif

// ===== rtl/cmps_pkg.sv =====
// shared types and constants for the correlation map position search
// no dependencies
`default_nettype none

package cmps_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAP_DEPTH = 256;
   localparam int DEF_DIST_BITS = 16;

   // fixed field widths
   localparam int COORD_BITS = 16;
   localparam int INDEX_BITS = 8;
   localparam int CNT_BITS   = 9;
   localparam int CORR_BITS  = 16;

   // correlation of 1.0 in unsigned Q1.15
   localparam logic [CORR_BITS-1:0] CORR_ONE = 16'h8000;

   // request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // search sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_MUL,
      ST_DIV,
      ST_CMP,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/cmps_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module cmps_ram #(
   parameter int WIDTH     = 64,
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/correlation_map_position_search_top.sv =====
// Correlation map position search: a load word gives no result. A query walks entries
// 0..count-1 (count clamped to at most MAP_DEPTH), each with one ram read, one fetch,
// DIST_BITS-1 bit-serial multiply steps, 16 restoring divide steps and one compare;
// an entry with a negative reference skips the multiply and divide steps.
// One query at a time; a finished result waits in the output register.
// Synchronous active-high reset clears the sequencer, the count register and rsp_valid.
// Depends on cmps_pkg and cmps_ram.
`default_nettype none

module correlation_map_position_search_top #(
   parameter int MAP_DEPTH = cmps_pkg::DEF_MAP_DEPTH,
   parameter int DIST_BITS = cmps_pkg::DEF_DIST_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [cmps_pkg::CNT_BITS-1:0]        csr_wr_data,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_type,
   input  wire logic [cmps_pkg::INDEX_BITS-1:0]      req_entry_index,
   input  wire logic signed [DIST_BITS-1:0]          req_front_dist,
   input  wire logic signed [DIST_BITS-1:0]          req_right_dist,
   input  wire logic signed [cmps_pkg::COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [cmps_pkg::COORD_BITS-1:0] req_coord_y,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_found,
   output logic signed [cmps_pkg::COORD_BITS-1:0]    rsp_best_x,
   output logic signed [cmps_pkg::COORD_BITS-1:0]    rsp_best_y,
   output logic [cmps_pkg::INDEX_BITS-1:0]           rsp_best_index,
   output logic [cmps_pkg::CORR_BITS-1:0]            rsp_best_correlation
);

   import cmps_pkg::*;

   // magnitude bits of a non-negative distance
   localparam int MAG_BITS  = DIST_BITS - 1;
   // product register: sums of up to four MAG_BITS squares, plus a shift bit
   localparam int PW        = 2 * MAG_BITS + 3;
   localparam int HW        = MAG_BITS + 3;
   localparam int ADDR_BITS = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int WORD_BITS = 2 * DIST_BITS + 2 * COORD_BITS;
   localparam int STEP_MAX  = (MAG_BITS > CORR_BITS) ? MAG_BITS : CORR_BITS;
   localparam int STEP_BITS = $clog2(STEP_MAX);
   localparam int CNT_MAX   = (MAP_DEPTH < (1 << CNT_BITS) - 1) ?
                              MAP_DEPTH : (1 << CNT_BITS) - 1;
   localparam logic [CNT_BITS-1:0]  CNT_LIMIT = CNT_MAX[CNT_BITS-1:0];
   localparam logic [STEP_BITS-1:0] MUL_LAST  = STEP_BITS'(MAG_BITS - 1);
   localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(CORR_BITS - 1);

   // sequencer
   state_type state_ff, state_in;

   // configuration
   logic [CNT_BITS-1:0] csr_count_ff, csr_count_in;
   logic [CNT_BITS-1:0] cnt_eff;

   // query operands
   logic [MAG_BITS-1:0] meas_f_ff, meas_f_in, meas_r_ff, meas_r_in;
   logic [MAG_BITS-1:0] ref_f_ff, ref_f_in, ref_r_ff, ref_r_in;
   logic                ref_neg_ff, ref_neg_in;
   logic [MAG_BITS-1:0] sh_mf_ff, sh_mf_in, sh_mr_ff, sh_mr_in;
   logic [MAG_BITS-1:0] sh_rf_ff, sh_rf_in, sh_rr_ff, sh_rr_in;
   logic signed [COORD_BITS-1:0] ent_x_ff, ent_x_in, ent_y_ff, ent_y_in;

   // arithmetic: dot_ff is the dot product, then the divide remainder
   logic [PW-1:0]        dot_ff, dot_in, en_ff, en_in;
   logic [CORR_BITS-1:0] quot_ff, quot_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   // scan position
   logic [ADDR_BITS-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_BITS-1:0]  scan_left_ff, scan_left_in;

   // running best
   logic                         best_found_ff, best_found_in;
   logic [CORR_BITS-1:0]         best_corr_ff, best_corr_in;
   logic signed [COORD_BITS-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [INDEX_BITS-1:0]        best_index_ff, best_index_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [INDEX_BITS-1:0]        rsp_index_ff, rsp_index_in;
   logic [CORR_BITS-1:0]         rsp_corr_ff, rsp_corr_in;

   // control decodes
   logic req_fire, query_fire, meas_neg;
   logic mem_wr_en, rsp_load;

   // memory
   logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;
   logic signed [DIST_BITS-1:0]  rd_front, rd_right;
   logic signed [COORD_BITS-1:0] rd_x, rd_y;

   // serial multiply and divide terms
   logic [MAG_BITS:0]    dot_add;
   logic [MAG_BITS+1:0]  en_add;
   logic [HW-1:0]        dot_hi, en_hi;
   logic [PW-1:0]        rem_sh;
   logic                 rem_ge;
   logic [CORR_BITS-1:0] score;
   logic                 win;

   // request handshake and effective count
   assign req_fire   = req_valid && !req_stall;
   assign query_fire = req_fire && (req_type == REQ_QUERY);
   assign meas_neg   = req_front_dist[DIST_BITS-1] || req_right_dist[DIST_BITS-1];
   assign cnt_eff    = (csr_count_ff > CNT_LIMIT) ? CNT_LIMIT : csr_count_ff;

   // map memory
   assign mem_wr_data = {req_front_dist, req_right_dist, req_coord_x, req_coord_y};

   cmps_ram #(
      .WIDTH     (WORD_BITS),
      .DEPTH     (MAP_DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ADDR_BITS'(req_entry_index)),
      .wr_data (mem_wr_data),
      .rd_addr (scan_addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rd_front = mem_rd_data[WORD_BITS-1 -: DIST_BITS];
   assign rd_right = mem_rd_data[2*COORD_BITS+DIST_BITS-1 -: DIST_BITS];
   assign rd_x     = mem_rd_data[2*COORD_BITS-1 -: COORD_BITS];
   assign rd_y     = mem_rd_data[COORD_BITS-1:0];

   // bit-serial addends, one multiplier bit of each operand per cycle
   assign dot_add = (sh_rf_ff[0] ? {1'b0, meas_f_ff} : '0)
                  + (sh_rr_ff[0] ? {1'b0, meas_r_ff} : '0);
   assign en_add  = (sh_rf_ff[0] ? {2'b00, ref_f_ff}  : '0)
                  + (sh_rr_ff[0] ? {2'b00, ref_r_ff}  : '0)
                  + (sh_mf_ff[0] ? {2'b00, meas_f_ff} : '0)
                  + (sh_mr_ff[0] ? {2'b00, meas_r_ff} : '0);
   assign dot_hi  = dot_ff[PW-1:MAG_BITS] + {2'b00, dot_add};
   assign en_hi   = en_ff[PW-1:MAG_BITS] + {1'b0, en_add};

   // restoring divide step
   assign rem_sh = {dot_ff[PW-2:0], 1'b0};
   assign rem_ge = (rem_sh >= en_ff);

   // clamp and compare against the running best
   assign score = (quot_ff > CORR_ONE) ? CORR_ONE : quot_ff;
   assign win   = !ref_neg_ff && (!best_found_ff || (score > best_corr_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = (meas_neg || (cnt_eff == '0)) ? ST_RESULT : ST_READ;
            end
         end
         ST_READ:  state_in = ST_FETCH;
         ST_FETCH: begin
            state_in = (rd_front[DIST_BITS-1] || rd_right[DIST_BITS-1]) ? ST_CMP : ST_MUL;
         end
         ST_MUL: begin
            if (step_ff == '0) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = (scan_left_ff == CNT_BITS'(1)) ? ST_RESULT : ST_READ;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      mem_wr_en = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_wr_en = req_valid && (req_type == REQ_LOAD)
                     && (32'(req_entry_index) < 32'(MAP_DEPTH));
         end
         ST_RESULT: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      csr_count_in  = csr_wr_en ? csr_wr_data : csr_count_ff;
      meas_f_in     = meas_f_ff;
      meas_r_in     = meas_r_ff;
      ref_f_in      = ref_f_ff;
      ref_r_in      = ref_r_ff;
      ref_neg_in    = ref_neg_ff;
      sh_mf_in      = sh_mf_ff;
      sh_mr_in      = sh_mr_ff;
      sh_rf_in      = sh_rf_ff;
      sh_rr_in      = sh_rr_ff;
      ent_x_in      = ent_x_ff;
      ent_y_in      = ent_y_ff;
      dot_in        = dot_ff;
      en_in         = en_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      scan_addr_in  = scan_addr_ff;
      scan_left_in  = scan_left_ff;
      best_found_in = best_found_ff;
      best_corr_in  = best_corr_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_index_in = best_index_ff;

      case (state_ff)
         // start of a query
         ST_IDLE: begin
            if (query_fire) begin
               meas_f_in     = req_front_dist[MAG_BITS-1:0];
               meas_r_in     = req_right_dist[MAG_BITS-1:0];
               scan_addr_in  = '0;
               scan_left_in  = cnt_eff;
               best_found_in = 1'b0;
            end
         end
         // capture the entry and arm the serial multiplier
         ST_FETCH: begin
            ref_f_in   = rd_front[MAG_BITS-1:0];
            ref_r_in   = rd_right[MAG_BITS-1:0];
            ref_neg_in = rd_front[DIST_BITS-1] || rd_right[DIST_BITS-1];
            sh_rf_in   = rd_front[MAG_BITS-1:0];
            sh_rr_in   = rd_right[MAG_BITS-1:0];
            sh_mf_in   = meas_f_ff;
            sh_mr_in   = meas_r_ff;
            ent_x_in   = rd_x;
            ent_y_in   = rd_y;
            dot_in     = '0;
            en_in      = '0;
            step_in    = MUL_LAST;
         end
         // shift-add, lsb first
         ST_MUL: begin
            dot_in   = PW'({dot_hi, dot_ff[MAG_BITS-1:0]} >> 1);
            en_in    = PW'({en_hi, en_ff[MAG_BITS-1:0]} >> 1);
            sh_mf_in = sh_mf_ff >> 1;
            sh_mr_in = sh_mr_ff >> 1;
            sh_rf_in = sh_rf_ff >> 1;
            sh_rr_in = sh_rr_ff >> 1;
            step_in  = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               step_in = DIV_LAST;
               quot_in = '0;
            end
         end
         // one quotient bit per cycle: 2*dot*2^15 / energy
         ST_DIV: begin
            dot_in  = rem_ge ? (rem_sh - en_ff) : rem_sh;
            quot_in = {quot_ff[CORR_BITS-2:0], rem_ge};
            step_in = step_ff - STEP_BITS'(1);
         end
         // keep the first strict maximum, move to the next entry
         ST_CMP: begin
            if (win) begin
               best_found_in = 1'b1;
               best_corr_in  = score;
               best_x_in     = ent_x_ff;
               best_y_in     = ent_y_ff;
               best_index_in = INDEX_BITS'(scan_addr_ff);
            end
            scan_addr_in = scan_addr_ff + ADDR_BITS'(1);
            scan_left_in = scan_left_ff - CNT_BITS'(1);
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_index_in = rsp_index_ff;
      rsp_corr_in  = rsp_corr_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = best_found_ff;
         rsp_x_in     = best_found_ff ? best_x_ff     : '0;
         rsp_y_in     = best_found_ff ? best_y_ff     : '0;
         rsp_index_in = best_found_ff ? best_index_ff : '0;
         rsp_corr_in  = best_found_ff ? best_corr_ff  : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_count_ff <= csr_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      meas_f_ff     <= meas_f_in;
      meas_r_ff     <= meas_r_in;
      ref_f_ff      <= ref_f_in;
      ref_r_ff      <= ref_r_in;
      ref_neg_ff    <= ref_neg_in;
      sh_mf_ff      <= sh_mf_in;
      sh_mr_ff      <= sh_mr_in;
      sh_rf_ff      <= sh_rf_in;
      sh_rr_ff      <= sh_rr_in;
      ent_x_ff      <= ent_x_in;
      ent_y_ff      <= ent_y_in;
      dot_ff        <= dot_in;
      en_ff         <= en_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      scan_addr_ff  <= scan_addr_in;
      scan_left_ff  <= scan_left_in;
      best_found_ff <= best_found_in;
      best_corr_ff  <= best_corr_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      best_index_ff <= best_index_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_corr_ff   <= rsp_corr_in;
   end

   // ports
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_best_x           = rsp_x_ff;
   assign rsp_best_y           = rsp_y_ff;
   assign rsp_best_index       = rsp_index_ff;
   assign rsp_best_correlation = rsp_corr_ff;

endmodule

`default_nettype wire

// ===== rtl/cmps_checker.sv =====
// port-level checks for the correlation map position search, bound to the top level
// depends on cmps_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cmps_checker #(
   parameter int DIST_BITS = cmps_pkg::DEF_DIST_BITS
) (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   csr_wr_en,
   input wire logic [cmps_pkg::CNT_BITS-1:0]          csr_wr_data,
   input wire logic                                   req_valid,
   input wire logic                                   req_stall,
   input wire logic                                   req_type,
   input wire logic [cmps_pkg::INDEX_BITS-1:0]        req_entry_index,
   input wire logic signed [DIST_BITS-1:0]            req_front_dist,
   input wire logic signed [DIST_BITS-1:0]            req_right_dist,
   input wire logic signed [cmps_pkg::COORD_BITS-1:0] req_coord_x,
   input wire logic signed [cmps_pkg::COORD_BITS-1:0] req_coord_y,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic                                   rsp_found,
   input wire logic signed [cmps_pkg::COORD_BITS-1:0] rsp_best_x,
   input wire logic signed [cmps_pkg::COORD_BITS-1:0] rsp_best_y,
   input wire logic [cmps_pkg::INDEX_BITS-1:0]        rsp_best_index,
   input wire logic [cmps_pkg::CORR_BITS-1:0]         rsp_best_correlation
);

   import cmps_pkg::*;

   // reset leaves the block empty and ready
   `CMPS_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && !req_stall)

   // a query word holds off the next request while it searches
   `CMPS_ASSERT(a_query_busy, req_valid && !req_stall && (req_type == REQ_QUERY) |=> req_stall)

   // a word waiting on the response side keeps its payload
   `CMPS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_best_x) && $stable(rsp_best_y) && $stable(rsp_best_index) && $stable(rsp_best_correlation))

   // correlation never exceeds 1.0
   `CMPS_ASSERT(a_corr_max, rsp_valid |-> rsp_best_correlation <= CORR_ONE)

   // a miss carries an all-zero payload
   `CMPS_ASSERT(a_miss_zero, rsp_valid && !rsp_found |-> rsp_best_x == 0 && rsp_best_y == 0 && rsp_best_index == 0 && rsp_best_correlation == 0)

endmodule

bind correlation_map_position_search_top cmps_checker #(
   .DIST_BITS (DIST_BITS)
) u_cmps_checker (.*);

`default_nettype wire

// ===== bench/correlation_map_position_search_top_tb.sv =====
// self-checking bench for the correlation map position search block
// keeps its own copy of the map, predicts each query result and compares it with the block
// depends on cmps_pkg and the correlation_map_position_search_top rtl
`timescale 1ns / 1ps

module correlation_map_position_search_top_tb;

   localparam int MAP_DEPTH     = cmps_pkg::DEF_MAP_DEPTH;
   localparam int DIST_W        = cmps_pkg::DEF_DIST_BITS;
   localparam int COORD_W       = cmps_pkg::COORD_BITS;
   localparam int INDEX_W       = cmps_pkg::INDEX_BITS;
   localparam int CNT_W         = cmps_pkg::CNT_BITS;
   localparam int CORR_W        = cmps_pkg::CORR_BITS;
   localparam int CORR_ONE_INT  = 32768;
   localparam int NO_SCORE      = -1;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 40000;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_ITEMS  = 100;
   localparam logic [CNT_W-1:0] COUNT_FULL     = 9'd256;
   localparam logic [CNT_W-1:0] COUNT_OVERSIZE = 9'd511;

   // one word on the request channel
   typedef struct packed {
      logic                       kind;
      logic [INDEX_W-1:0]         index;
      logic signed [DIST_W-1:0]   front;
      logic signed [DIST_W-1:0]   right;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
   } map_req_t;

   // one word on the result channel
   typedef struct packed {
      logic                       found;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic [INDEX_W-1:0]         index;
      logic [CORR_W-1:0]          corr;
   } position_t;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CNT_W-1:0]           csr_wr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_type;
   logic [INDEX_W-1:0]         req_entry_index;
   logic signed [DIST_W-1:0]   req_front_dist;
   logic signed [DIST_W-1:0]   req_right_dist;
   logic signed [COORD_W-1:0]  req_coord_x;
   logic signed [COORD_W-1:0]  req_coord_y;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_found;
   logic signed [COORD_W-1:0]  rsp_best_x;
   logic signed [COORD_W-1:0]  rsp_best_y;
   logic [INDEX_W-1:0]         rsp_best_index;
   logic [CORR_W-1:0]          rsp_best_correlation;

   // bench copy of the map and the search count
   logic signed [DIST_W-1:0]   map_front [MAP_DEPTH];
   logic signed [DIST_W-1:0]   map_right [MAP_DEPTH];
   logic signed [COORD_W-1:0]  map_x     [MAP_DEPTH];
   logic signed [COORD_W-1:0]  map_y     [MAP_DEPTH];
   logic [CNT_W-1:0]           search_count;

   position_t                  expected_positions [$];
   int                         mismatch_count;
   bit                         req_idle_on;
   bit                         rsp_idle_on;
   bit                         hold_long;

   correlation_map_position_search_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_entry_index      (req_entry_index),
      .req_front_dist       (req_front_dist),
      .req_right_dist       (req_right_dist),
      .req_coord_x          (req_coord_x),
      .req_coord_y          (req_coord_y),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_best_x           (rsp_best_x),
      .rsp_best_y           (rsp_best_y),
      .rsp_best_index       (rsp_best_index),
      .rsp_best_correlation (rsp_best_correlation)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // correlation of one entry in Q1.15, or NO_SCORE for a negative reference
   function automatic int entry_score(input longint mf, input longint mr,
                                      input longint rf, input longint rr);
      longint dot;
      longint energy;
      longint q;
      if (rf < 0 || rr < 0) return NO_SCORE;
      dot    = mf * rf + mr * rr;
      energy = mf * mf + mr * mr + rf * rf + rr * rr;
      if (energy == 0) return CORR_ONE_INT;
      q = (dot * 2 * CORR_ONE_INT) / energy;
      if (q > CORR_ONE_INT) q = CORR_ONE_INT;
      return int'(q);
   endfunction

   // walk the bench map and keep the first strict maximum
   function automatic position_t predict_position(input logic signed [DIST_W-1:0] mf,
                                                  input logic signed [DIST_W-1:0] mr);
      position_t r;
      int        best;
      int        s;
      int        lim;
      int        i;
      r    = '0;
      best = NO_SCORE;
      lim  = (search_count > MAP_DEPTH) ? MAP_DEPTH : int'(search_count);
      if (mf >= 0 && mr >= 0) begin
         for (i = 0; i < lim; i++) begin
            s = entry_score(mf, mr, map_front[i], map_right[i]);
            if (s > best) begin
               best    = s;
               r.found = 1'b1;
               r.x     = map_x[i];
               r.y     = map_y[i];
               r.index = i[INDEX_W-1:0];
               r.corr  = s[CORR_W-1:0];
            end
         end
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what, input position_t want,
                                input position_t got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch (%s) at %0t: expected found=%0d x=%0d y=%0d idx=%0d corr=%0d",
                  what, $realtime, want.found, want.x, want.y, want.index, want.corr);
         $display("   actual found=%0d x=%0d y=%0d idx=%0d corr=%0d",
                  got.found, got.x, got.y, got.index, got.corr);
      end
   endtask

   // track config and loads, predict queries, compare results
   always @(posedge clock) begin : scoreboard
      position_t got;
      position_t want;
      if (!reset) begin
         if (csr_wr_en) search_count = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got.found = rsp_found;
            got.x     = rsp_best_x;
            got.y     = rsp_best_y;
            got.index = rsp_best_index;
            got.corr  = rsp_best_correlation;
            if (expected_positions.size() == 0) begin
               note_mismatch("unexpected word", '0, got);
            end else begin
               want = expected_positions.pop_front();
               if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
                   got.index !== want.index || got.corr !== want.corr)
                  note_mismatch("field", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == cmps_pkg::REQ_LOAD) begin
               if (req_entry_index < MAP_DEPTH) begin
                  map_front[req_entry_index] = req_front_dist;
                  map_right[req_entry_index] = req_right_dist;
                  map_x[req_entry_index]     = req_coord_x;
                  map_y[req_entry_index]     = req_coord_y;
               end
            end else begin
               expected_positions.push_back(predict_position(req_front_dist, req_right_dist));
            end
         end
      end
   end

   // result side pacing: per word wait, plus one long hold-off on request
   initial begin : rsp_pacing
      int wait_left;
      wait_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            wait_left = rsp_idle_on ? $urandom_range(0, 3) : 0;
            rsp_stall <= (wait_left != 0);
         end else if (!rsp_valid && hold_long) begin
            hold_long = 1'b0;
            wait_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && wait_left > 0) begin
            wait_left--;
            if (wait_left == 0) rsp_stall <= 1'b0;
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // offer one word, after a random gap, and hold it until taken
   task automatic send_word(input map_req_t w);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= w.kind;
      req_entry_index <= w.index;
      req_front_dist  <= w.front;
      req_right_dist  <= w.right;
      req_coord_x     <= w.x;
      req_coord_y     <= w.y;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering, let every result arrive and any load finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_positions.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic map_req_t load_word(input int idx, input int f, input int r,
                                          input int x, input int y);
      map_req_t w;
      w.kind  = cmps_pkg::REQ_LOAD;
      w.index = idx[INDEX_W-1:0];
      w.front = f[DIST_W-1:0];
      w.right = r[DIST_W-1:0];
      w.x     = x[COORD_W-1:0];
      w.y     = y[COORD_W-1:0];
      return w;
   endfunction

   function automatic map_req_t query_word(input int f, input int r);
      map_req_t w;
      w       = load_word($urandom, f, r, $urandom, $urandom);
      w.kind  = cmps_pkg::REQ_QUERY;
      return w;
   endfunction

   // distance: mostly non-negative, narrow ranges make ties likely
   function automatic int draw_dist(input bit narrow);
      if ($urandom_range(0, 6) == 0) return int'($signed(16'($urandom)));
      if (narrow) return $urandom_range(0, 3);
      return $urandom_range(0, 32767);
   endfunction

   function automatic map_req_t draw_word(input bit narrow, input int load_pct);
      if ($urandom_range(0, 99) < load_pct)
         return load_word($urandom_range(0, MAP_DEPTH - 1), draw_dist(narrow),
                          draw_dist(narrow), $urandom, $urandom);
      return query_word(draw_dist(narrow), draw_dist(narrow));
   endfunction

   // count of zero from reset, then a map where nothing can win
   task automatic test_empty_search();
      send_word(query_word(10, 20));
      send_word(query_word(-1, 0));
      wait_idle();
      send_word(load_word(0, -1, 10, 1, 2));
      wait_idle();
      write_count(9'd1);
      send_word(query_word(10, 10));
      wait_idle();
   endtask

   // zero energy, negative references, ties, clamping, bad measurements
   task automatic test_special_entries();
      send_word(load_word(0, 0, 0, -32768, 32767));
      send_word(load_word(1, -32768, 100, 5, 5));
      send_word(load_word(2, 100, -1, 6, 6));
      send_word(load_word(3, 32767, 32767, 32767, -32768));
      send_word(load_word(4, 100, 200, 4, 40));
      send_word(load_word(5, 100, 200, 5, 50));
      send_word(load_word(6, 0, 32767, 6, 60));
      send_word(load_word(7, 32767, 0, 7, 70));
      wait_idle();
      write_count(9'd8);
      send_word(query_word(0, 0));
      send_word(query_word(100, 200));
      send_word(query_word(32767, 32767));
      send_word(query_word(0, 32767));
      send_word(query_word(32767, 0));
      send_word(query_word(50, 100));
      send_word(query_word(-1, 0));
      send_word(query_word(0, -32768));
      wait_idle();
      write_count(9'd0);
      send_word(query_word(50, 100));
      wait_idle();
   endtask

   // fill every slot in shuffled order, then search the whole map
   task automatic test_full_map();
      int order [MAP_DEPTH];
      int i;
      int j;
      int t;
      for (i = 0; i < MAP_DEPTH; i++) order[i] = i;
      for (i = MAP_DEPTH - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < MAP_DEPTH; i++)
         send_word(load_word(order[i], draw_dist(1'b0), draw_dist(1'b0), $urandom, $urandom));
      wait_idle();
      write_count(COUNT_FULL);
      send_word(query_word(draw_dist(1'b0), draw_dist(1'b0)));
      send_word(query_word($urandom_range(0, 32767), $urandom_range(0, 32767)));
      wait_idle();
      // count above the map depth searches the whole map
      write_count(COUNT_OVERSIZE);
      send_word(query_word($urandom_range(0, 32767), $urandom_range(0, 32767)));
      wait_idle();
   endtask

   // long result hold-off while queries keep coming
   task automatic test_back_pressure();
      int i;
      write_count(9'd4);
      req_idle_on = 1'b0;
      hold_long   = 1'b1;
      for (i = 0; i < 8; i++) begin
         if (i == 3 || i == 6) send_word(draw_word(1'b0, 100));
         else send_word(query_word(draw_dist(1'b0), draw_dist(1'b0)));
      end
      wait_idle();
      req_idle_on = 1'b1;
   endtask

   // phases of random traffic under varying counts
   task automatic test_random_traffic();
      int sent;
      int phase;
      int n;
      int i;
      int pick;
      bit narrow;
      logic [CNT_W-1:0] count;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (phase == 3) count = COUNT_FULL;
         else if (pick == 0) count = 9'd0;
         else if (pick == 1) count = 9'($urandom_range(13, 64));
         else count = 9'($urandom_range(1, 12));
         write_count(count);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         narrow      = ($urandom_range(0, 9) < 3);
         n = (phase == 3) ? 4 : $urandom_range(6, 14);
         for (i = 0; i < n; i++) send_word(draw_word(narrow, 35));
         sent += n;
         phase++;
         wait_idle();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      mismatch_count  = 0;
      search_count    = '0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      hold_long       = 1'b0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_valid       <= 1'b0;
      req_type        <= cmps_pkg::REQ_LOAD;
      req_entry_index <= '0;
      req_front_dist  <= '0;
      req_right_dist  <= '0;
      req_coord_x     <= '0;
      req_coord_y     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_search();
      test_special_entries();
      test_full_map();
      test_back_pressure();
      test_random_traffic();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_positions.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cmps_pkg.sv
rtl/cmps_ram.sv
rtl/correlation_map_position_search_top.sv
rtl/cmps_checker.sv
bench/correlation_map_position_search_top_tb.sv
